>>> sv/mle_pkg.sv
`default_nettype none
package mle_pkg;

  // Longest symbol that can be entered; a seventh element decodes to 0.
  localparam int unsigned MAX_ELEMENTS = 7;
  localparam int unsigned DECODE_LIMIT = 6;

  // Text buffer size; the 8-bit text_length field caps it.
  localparam int unsigned TEXT_DEPTH = 128;

  localparam logic [6:0] CH_SPACE = 7'h20;
  localparam logic [6:0] CH_CR    = 7'h0d;
  localparam logic [6:0] CH_LF    = 7'h0a;

  typedef enum logic [2:0] {
    KIND_DOT      = 3'd0,
    KIND_DASH     = 3'd1,
    KIND_COMMIT   = 3'd2,
    KIND_NEWLINE  = 3'd3,
    KIND_BACKSP   = 3'd4,
    KIND_CLR_SYM  = 3'd5,
    KIND_CLR_TEXT = 3'd6,
    KIND_READ     = 3'd7
  } kind_e;

  // Classified key event, one flag per operation.
  typedef struct packed {
    logic       elem;
    logic       dash;
    logic       commit;
    logic       newline;
    logic       bksp;
    logic       clr_sym;
    logic       clr_txt;
    logic       rd;
    logic [6:0] read_index;
  } op_t;

  // Result beat, last field in the lowest bits.
  typedef struct packed {
    logic       overflow;
    logic [2:0] symbol_elements;
    logic [6:0] read_char;
    logic [7:0] text_length;
    logic [6:0] preview_char;
  } res_t;

  // Element bits with a marker just above the last one.
  function automatic logic [6:0] morse_lut(input logic [6:0] idx);
    logic [6:0] ch;
    unique case (idx)
      7'd2:    ch = 7'("E");
      7'd3:    ch = 7'("T");
      7'd4:    ch = 7'("I");
      7'd5:    ch = 7'("N");
      7'd6:    ch = 7'("A");
      7'd7:    ch = 7'("M");
      7'd8:    ch = 7'("S");
      7'd9:    ch = 7'("D");
      7'd10:   ch = 7'("R");
      7'd11:   ch = 7'("G");
      7'd12:   ch = 7'("U");
      7'd13:   ch = 7'("K");
      7'd14:   ch = 7'("W");
      7'd15:   ch = 7'("O");
      7'd16:   ch = 7'("H");
      7'd17:   ch = 7'("B");
      7'd18:   ch = 7'("L");
      7'd19:   ch = 7'("Z");
      7'd20:   ch = 7'("F");
      7'd21:   ch = 7'("C");
      7'd22:   ch = 7'("P");
      7'd24:   ch = 7'("V");
      7'd25:   ch = 7'("X");
      7'd27:   ch = 7'("Q");
      7'd29:   ch = 7'("Y");
      7'd30:   ch = 7'("J");
      7'd32:   ch = 7'("5");
      7'd33:   ch = 7'("6");
      7'd35:   ch = 7'("7");
      7'd39:   ch = 7'("8");
      7'd41:   ch = 7'("/");
      7'd45:   ch = 7'("(");
      7'd47:   ch = 7'("9");
      7'd48:   ch = 7'("4");
      7'd49:   ch = 7'("=");
      7'd56:   ch = 7'("3");
      7'd60:   ch = 7'("2");
      7'd62:   ch = 7'("1");
      7'd63:   ch = 7'("0");
      7'd71:   ch = 7'(":");
      7'd76:   ch = 7'("?");
      7'd82:   ch = 7'h22;
      7'd86:   ch = 7'("@");
      7'd94:   ch = 7'h27;
      7'd97:   ch = 7'("-");
      7'd106:  ch = 7'(".");
      7'd108:  ch = 7'("_");
      7'd109:  ch = 7'(")");
      7'd115:  ch = 7'(",");
      7'd117:  ch = 7'("!");
      default: ch = 7'd0;
    endcase
    return ch;
  endfunction

  function automatic logic [6:0] decode_sym(input logic [6:0] pat, input logic [2:0] cnt);
    logic [6:0] marker;
    logic [6:0] ch;
    marker = 7'd1 << cnt;
    if (cnt == 3'd0) begin
      ch = CH_SPACE;
    end else if (cnt > 3'(DECODE_LIMIT)) begin
      ch = 7'd0;
    end else begin
      ch = morse_lut(marker | (pat & (marker - 7'd1)));
    end
    return ch;
  endfunction

endpackage
`default_nettype wire

>>> sv/mle_front.sv
`default_nettype none
module mle_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic [2:0]    in_kind_i,
  input  wire logic [6:0]    in_index_i,
  output logic               q_valid_o,
  output mle_pkg::op_t       q_op_o,
  input  wire logic          q_pop_i
);
  import mle_pkg::*;

  op_t        ent_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push;
  op_t        op_new;

  always_comb begin
    op_new            = '0;
    op_new.read_index = in_index_i;
    unique case (kind_e'(in_kind_i))
      KIND_DOT:      op_new.elem    = 1'b1;
      KIND_DASH:     begin
        op_new.elem = 1'b1;
        op_new.dash = 1'b1;
      end
      KIND_COMMIT:   op_new.commit  = 1'b1;
      KIND_NEWLINE:  op_new.newline = 1'b1;
      KIND_BACKSP:   op_new.bksp    = 1'b1;
      KIND_CLR_SYM:  op_new.clr_sym = 1'b1;
      KIND_CLR_TEXT: op_new.clr_txt = 1'b1;
      KIND_READ:     op_new.rd      = 1'b1;
      default:       op_new.rd      = 1'b1;
    endcase
  end

  assign in_ready_o = (cnt_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_op_o     = ent_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wr_ptr_q] <= op_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (q_pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_q + 2'(push) - 2'(q_pop_i);
    end
  end

endmodule
`default_nettype wire

>>> sv/mle_back.sv
`default_nettype none
module mle_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          q_valid_i,
  input  mle_pkg::op_t       q_op_i,
  output logic               q_pop_o,
  output logic               res_valid_o,
  input  wire logic          res_ready_i,
  output mle_pkg::res_t      res_o
);
  import mle_pkg::*;

  localparam int unsigned AW = $clog2(TEXT_DEPTH);
  localparam int unsigned CW = $clog2(TEXT_DEPTH + 1);
  localparam int unsigned IW = (CW > 7) ? CW : 7;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_LF
  } state_e;

  state_e          state_q, state_d;
  op_t             op_q, op_d;
  logic [6:0]      pat_q, pat_d;
  logic [2:0]      scnt_q, scnt_d;
  logic [CW-1:0]   tcnt_q, tcnt_d;
  logic            res_valid_q, res_valid_d;
  res_t            res_q, res_d;

  logic [6:0]      mem [TEXT_DEPTH];
  logic [6:0]      rd_data_q;
  logic [AW-1:0]   rd_addr;
  logic            we;
  logic [AW-1:0]   wa;
  logic [6:0]      wd;
  logic            fin;
  logic            ovf;
  logic [6:0]      rchar;
  logic [CW-1:0]   bs_cnt;

  assign q_pop_o     = (state_q == ST_IDLE) && q_valid_i && (!res_valid_q || res_ready_i);
  // backspace peeks at the last character, read peeks at the requested slot
  assign rd_addr     = q_op_i.bksp ? AW'(tcnt_q - CW'(1)) : AW'(q_op_i.read_index);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    pat_d       = pat_q;
    scnt_d      = scnt_q;
    tcnt_d      = tcnt_q;
    res_valid_d = res_valid_q && !res_ready_i;
    res_d       = res_q;
    we          = 1'b0;
    wa          = AW'(tcnt_q);
    wd          = CH_CR;
    fin         = 1'b0;
    ovf         = 1'b0;
    rchar       = 7'd0;
    bs_cnt      = tcnt_q - CW'(1);
    unique case (state_q)
      ST_IDLE: begin
        if (q_pop_o) begin
          op_d    = q_op_i;
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        fin = 1'b1;
        priority if (op_q.elem) begin
          if (scnt_q < 3'(MAX_ELEMENTS)) begin
            pat_d[scnt_q] = op_q.dash;
            scnt_d        = scnt_q + 3'd1;
          end else begin
            ovf = 1'b1;
          end
        end else if (op_q.commit) begin
          if (tcnt_q < CW'(TEXT_DEPTH)) begin
            we     = 1'b1;
            wd     = decode_sym(pat_q, scnt_q);
            tcnt_d = tcnt_q + CW'(1);
            pat_d  = 7'd0;
            scnt_d = 3'd0;
          end else begin
            ovf = 1'b1;
          end
        end else if (op_q.newline) begin
          if ({1'b0, tcnt_q} + (CW+1)'(2) <= (CW+1)'(TEXT_DEPTH)) begin
            we      = 1'b1;
            wd      = CH_CR;
            fin     = 1'b0;
            state_d = ST_LF;
          end else begin
            ovf = 1'b1;
          end
        end else if (op_q.bksp) begin
          if (tcnt_q != '0) begin
            // LF takes its CR with it
            if (rd_data_q == CH_LF && bs_cnt != '0) begin
              tcnt_d = bs_cnt - CW'(1);
            end else begin
              tcnt_d = bs_cnt;
            end
          end
        end else if (op_q.clr_sym) begin
          pat_d  = 7'd0;
          scnt_d = 3'd0;
        end else if (op_q.clr_txt) begin
          tcnt_d = '0;
        end else if (op_q.rd) begin
          if (IW'(op_q.read_index) < IW'(tcnt_q)) begin
            rchar = rd_data_q;
          end
        end
      end
      ST_LF: begin
        we     = 1'b1;
        wa     = AW'(tcnt_q + CW'(1));
        wd     = CH_LF;
        tcnt_d = tcnt_q + CW'(2);
        fin    = 1'b1;
      end
      default: state_d = ST_IDLE;
    endcase
    if (fin) begin
      state_d               = ST_IDLE;
      res_valid_d           = 1'b1;
      res_d.preview_char    = decode_sym(pat_d, scnt_d);
      res_d.text_length     = 8'(tcnt_d);
      res_d.read_char       = rchar;
      res_d.symbol_elements = scnt_d;
      res_d.overflow        = ovf;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= '0;
      pat_q       <= 7'd0;
      scnt_q      <= 3'd0;
      tcnt_q      <= '0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      pat_q       <= pat_d;
      scnt_q      <= scnt_d;
      tcnt_q      <= tcnt_d;
      res_valid_q <= res_valid_d;
      res_q       <= res_d;
    end
  end

endmodule
`default_nettype wire

>>> sv/morse_line_editor.sv
`default_nettype none
// Channel   Dir  Signals                     Content
// s_axis    in   tvalid/tready/tuser/tdata   one key event per beat
// m_axis    out  tvalid/tready/tdata         editor state after that event
//
// Events sit in a two-entry queue; the executor handles each event in steps
// (queue pop with text memory read, then update), with an extra LF step for
// newline, which needs two writes through the single memory write port.
// Reset clears symbol, text length, queue and result register; the text
// memory is not cleared. Each side stalls on its own; a waiting result
// holds the executor but not the queue.
module morse_line_editor (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [2:0]  s_axis_tuser_i,   // kind
  input  wire logic [7:0]  s_axis_tdata_i,   // [6:0] read_index, [7] zero
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [31:0]      m_axis_tdata_o    // [6:0] preview_char, [14:7] text_length,
                                             // [21:15] read_char, [24:22] symbol_elements,
                                             // [25] overflow, [31:26] zero
);
  import mle_pkg::*;

  logic q_valid;
  logic q_pop;
  op_t  q_op;
  res_t res;

  mle_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_kind_i  (s_axis_tuser_i),
    .in_index_i (s_axis_tdata_i[6:0]),
    .q_valid_o  (q_valid),
    .q_op_o     (q_op),
    .q_pop_i    (q_pop)
  );

  mle_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_op_i      (q_op),
    .q_pop_o     (q_pop),
    .res_valid_o (m_axis_tvalid_o),
    .res_ready_i (m_axis_tready_i),
    .res_o       (res)
  );

  assign m_axis_tdata_o = {6'd0, res};

endmodule
`default_nettype wire
